// ===== design/bsd_pkg.sv =====
// Shared types and constants of the boundary-aware stencil derivative unit.
package bsd_pkg;

    // Request type codes
    localparam logic [1:0] REQ_FIELD_WR = 2'd0;
    localparam logic [1:0] REQ_COEF_WR  = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_HALF_WIDTH = 3'd0;
    localparam logic [2:0] CFG_TOP_X      = 3'd1;
    localparam logic [2:0] CFG_TOP_Y      = 3'd2;
    localparam logic [2:0] CFG_TOP_Z      = 3'd3;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // Result status codes
    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_SAT  = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // Command queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_FIELD_WR,
        CMD_COEF_WR,
        CMD_QUERY,
        CMD_BAD
    } cmd_kind_t;

    // Classified command; widths cover the largest half width of eight
    typedef struct packed {
        cmd_kind_t   kind;
        logic [1:0]  comp;
        logic [1:0]  axis;
        logic [3:0]  pos_i;
        logic [3:0]  pos_j;
        logic [3:0]  pos_k;
        logic [4:0]  set;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [4:0]  np;
        logic [4:0]  taps;
        logic [31:0] value;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_CENTRE,
        B_TAPS,
        B_FINISH
    } back_state_t;

endpackage

// ===== design/boundary_aware_stencil_derivative_unit.sv =====
// Queries are handled one at a time: the single field memory read port takes the centre read
// and then one tap per cycle, and the multiply/accumulate pipeline drains before the next query.
// Writes retire one per cycle while the back end is idle; a two-entry queue lets input be
// taken while a result waits.
// Reset: configuration returns to half width 1 and top indices 15, the queue and result
// register empty; field and coefficient memories hold undefined data until written.
module boundary_aware_stencil_derivative_unit
    import bsd_pkg::*;
#(
    parameter int MAX_HALF_WIDTH  = 4,
    parameter int GRID_INDEX_BITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [1:0]  axis,
    input  logic [1:0]  component,
    input  logic [3:0]  pos_i,
    input  logic [3:0]  pos_j,
    input  logic [3:0]  pos_k,
    input  logic [3:0]  deriv_order,
    input  logic [3:0]  coef_set,
    input  logic [2:0]  coef_row,
    input  logic [2:0]  coef_col,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] derivative,
    output logic [1:0]  status
);

    cmd_t push_cmd;
    cmd_t head;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;

    // Accept and classify
    bsd_front #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .GRID_INDEX_BITS(GRID_INDEX_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .axis       (axis),
        .component  (component),
        .pos_i      (pos_i),
        .pos_j      (pos_j),
        .pos_k      (pos_k),
        .deriv_order(deriv_order),
        .coef_set   (coef_set),
        .coef_row   (coef_row),
        .coef_col   (coef_col),
        .value      (value),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_cmd      (push_cmd)
    );

    // Buffer classified transactions
    bsd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(push_cmd),
        .pop     (q_pop),
        .head    (head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // Execute writes and queries
    bsd_back #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .GRID_INDEX_BITS(GRID_INDEX_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .derivative(derivative),
        .status    (status)
    );

endmodule

// ===== design/bsd_front.sv =====
// Front end: configuration registers, input acceptance and request classification.
module bsd_front
    import bsd_pkg::*;
#(
    parameter int MAX_HALF_WIDTH  = 4,
    parameter int GRID_INDEX_BITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  req_type,
    input  logic [1:0]  axis,
    input  logic [1:0]  component,
    input  logic [3:0]  pos_i,
    input  logic [3:0]  pos_j,
    input  logic [3:0]  pos_k,
    input  logic [3:0]  deriv_order,
    input  logic [3:0]  coef_set,
    input  logic [2:0]  coef_row,
    input  logic [2:0]  coef_col,
    input  logic [31:0] value,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    localparam int COEF_DIM  = 2 * MAX_HALF_WIDTH;
    localparam int COEF_SETS = 2 * MAX_HALF_WIDTH + 1;
    localparam logic [8:0] GRID_MAX = 9'((1 << GRID_INDEX_BITS) - 1);

    logic [2:0] half_width_reg;
    logic [3:0] top_x_reg;
    logic [3:0] top_y_reg;
    logic [3:0] top_z_reg;

    logic [4:0] hw;
    logic [4:0] two_hw;
    logic [4:0] p;
    logic [4:0] top_a;
    logic [4:0] w;
    logic [4:0] set;
    logic [4:0] np;
    logic       bad;
    logic       coef_ok;

    // Take configuration writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= 3'd1;
            top_x_reg      <= 4'd15;
            top_y_reg      <= 4'd15;
            top_z_reg      <= 4'd15;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HALF_WIDTH: half_width_reg <= cfg_data[2:0];
                CFG_TOP_X:      top_x_reg      <= cfg_data[3:0];
                CFG_TOP_Y:      top_y_reg      <= cfg_data[3:0];
                CFG_TOP_Z:      top_z_reg      <= cfg_data[3:0];
                default:        ;
            endcase
        end
    end

    // Classify the incoming request
    always_comb
    begin
        hw     = {2'b00, half_width_reg};
        two_hw = hw << 1;
        case (axis)
            AXIS_X:  begin p = {1'b0, pos_i}; top_a = {1'b0, top_x_reg}; end
            AXIS_Y:  begin p = {1'b0, pos_j}; top_a = {1'b0, top_y_reg}; end
            default: begin p = {1'b0, pos_k}; top_a = {1'b0, top_z_reg}; end
        endcase

        bad = 1'b0;
        if (axis == 2'd3 || component == 2'd3 || hw == 5'd0
            || 32'(hw) > 32'(MAX_HALF_WIDTH))
            bad = 1'b1;
        if (deriv_order == 4'd0 || {1'b0, deriv_order} > two_hw)
            bad = 1'b1;
        if ({5'd0, top_x_reg} > GRID_MAX || pos_i > top_x_reg)
            bad = 1'b1;
        if ({5'd0, top_y_reg} > GRID_MAX || pos_j > top_y_reg)
            bad = 1'b1;
        if ({5'd0, top_z_reg} > GRID_MAX || pos_k > top_z_reg)
            bad = 1'b1;
        if (top_a < two_hw)
            bad = 1'b1;

        // Pick the stencil set; lower boundary wins
        w = 5'd0;
        if (p < hw)
        begin
            set = hw - p;
            np  = hw + set;
        end
        else if (p + hw > top_a)
        begin
            w   = p + hw - top_a;
            np  = hw - w;
            set = w + hw;
        end
        else
        begin
            set = 5'd0;
            np  = hw;
        end

        coef_ok = 32'(coef_set) < COEF_SETS && 32'(coef_row) < COEF_DIM
                  && 32'(coef_col) < COEF_DIM;

        q_cmd.comp  = component;
        q_cmd.axis  = axis;
        q_cmd.pos_i = pos_i;
        q_cmd.pos_j = pos_j;
        q_cmd.pos_k = pos_k;
        q_cmd.value = value;
        q_cmd.np    = np;
        q_cmd.taps  = two_hw;
        if (req_type == REQ_COEF_WR)
        begin
            q_cmd.set = {1'b0, coef_set};
            q_cmd.row = {1'b0, coef_row};
            q_cmd.col = {1'b0, coef_col};
        end
        else
        begin
            q_cmd.set = set;
            q_cmd.row = deriv_order - 4'd1;
            q_cmd.col = 4'd0;
        end

        q_cmd.kind = CMD_BAD;
        q_push     = 1'b0;
        case (req_type)
            REQ_FIELD_WR:
            begin
                q_cmd.kind = CMD_FIELD_WR;
                q_push     = in_valid && !q_full && component != 2'd3;
            end
            REQ_COEF_WR:
            begin
                q_cmd.kind = CMD_COEF_WR;
                q_push     = in_valid && !q_full && coef_ok;
            end
            REQ_QUERY:
            begin
                q_cmd.kind = bad ? CMD_BAD : CMD_QUERY;
                q_push     = in_valid && !q_full;
            end
            default: ;
        endcase
    end

    // Hold the input while the queue is full
    assign in_stall = q_full;

endmodule

// ===== design/bsd_queue.sv =====
// Command queue decoupling the front end from the back end.
module bsd_queue
    import bsd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full  = count_reg == CW'(QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rd_ptr_reg];

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // Advance pointers and the fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (32'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (32'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// ===== design/bsd_back.sv =====
// Back end: field and coefficient memories, tap sequencer and result register.
module bsd_back
    import bsd_pkg::*;
#(
    parameter int MAX_HALF_WIDTH  = 4,
    parameter int GRID_INDEX_BITS = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] derivative,
    output logic [1:0]  status
);

    localparam int COEF_DIM   = 2 * MAX_HALF_WIDTH;
    localparam int COEF_SETS  = 2 * MAX_HALF_WIDTH + 1;
    localparam int COEF_DEPTH = COEF_SETS * COEF_DIM * COEF_DIM;
    localparam int CA         = $clog2(COEF_DEPTH);
    localparam int G          = GRID_INDEX_BITS;
    localparam int FA         = 3 * G + 2;

    logic [31:0] field_mem [1 << FA];
    logic [31:0] coef_mem [COEF_DEPTH];

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;
    logic [4:0]  m_reg, m_next;
    logic signed [31:0] centre_reg, centre_next;
    logic        v1_reg, v1_next;
    logic        v2_reg;
    logic        v3_reg;
    logic signed [32:0] diff_reg;
    logic signed [31:0] coef_reg;
    logic signed [64:0] prod_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] derivative_reg, derivative_next;
    logic [1:0]  status_reg, status_next;

    logic [FA-1:0] f_raddr;
    logic [CA-1:0] c_raddr;
    logic [31:0]   f_rdata;
    logic [31:0]   c_rdata;
    logic          f_we;
    logic          c_we;
    logic [FA-1:0] f_waddr;
    logic [CA-1:0] c_waddr;
    logic          out_free;
    logic [5:0]    tap_pos;
    logic [3:0]    pt_i;
    logic [3:0]    pt_j;
    logic [3:0]    pt_k;
    logic signed [48:0] rounded;

    function automatic logic [FA-1:0] faddr(logic [3:0] i, logic [3:0] j,
                                            logic [3:0] k, logic [1:0] c);
        logic [7:0] ie;
        logic [7:0] je;
        logic [7:0] ke;
        ie = {4'd0, i};
        je = {4'd0, j};
        ke = {4'd0, k};
        return {ie[G-1:0], je[G-1:0], ke[G-1:0], c};
    endfunction

    function automatic logic [CA-1:0] caddr(logic [4:0] s, logic [3:0] r,
                                            logic [4:0] c);
        return CA'((32'(s) * COEF_DIM + 32'(r)) * COEF_DIM + 32'(c));
    endfunction

    function automatic logic [3:0] pt_axis();
        case (cmd_reg.axis)
            AXIS_X:  return cmd_reg.pos_i;
            AXIS_Y:  return cmd_reg.pos_j;
            default: return cmd_reg.pos_k;
        endcase
    endfunction

    assign out_free = !out_valid_reg || !out_stall;

    // Place the current tap along the query axis
    always_comb
    begin
        if (m_reg < cmd_reg.np)
            tap_pos = 6'(pt_axis()) + 6'(m_reg) + 6'd1;
        else
            tap_pos = 6'(pt_axis()) + 6'(cmd_reg.np) - 6'(m_reg) - 6'd1;
        pt_i = cmd_reg.pos_i;
        pt_j = cmd_reg.pos_j;
        pt_k = cmd_reg.pos_k;
        case (cmd_reg.axis)
            AXIS_X:  pt_i = tap_pos[3:0];
            AXIS_Y:  pt_j = tap_pos[3:0];
            default: pt_k = tap_pos[3:0];
        endcase
    end

    // Write and read the memories
    always_ff @(posedge clk)
    begin
        if (f_we)
            field_mem[f_waddr] <= head.value;
        f_rdata <= field_mem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (c_we)
            coef_mem[c_waddr] <= head.value;
        c_rdata <= coef_mem[c_raddr];
    end

    // Tap datapath: difference, product
    always_ff @(posedge clk)
    begin
        diff_reg <= 33'($signed(f_rdata)) - 33'(centre_reg);
        coef_reg <= $signed(c_rdata);
        prod_reg <= 65'(coef_reg) * 65'(diff_reg);
    end

    assign rounded = 49'((prod_reg + 65'sd32768) >>> 16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            m_reg         <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        centre_reg     <= centre_next;
        acc_reg        <= acc_next;
        derivative_reg <= derivative_next;
        status_reg     <= status_next;
    end

    // Sequence commands and taps
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        m_next          = m_reg;
        centre_next     = centre_reg;
        acc_next        = acc_reg;
        v1_next         = 1'b0;
        derivative_next = derivative_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        q_pop           = 1'b0;
        f_we            = 1'b0;
        c_we            = 1'b0;
        f_waddr         = faddr(head.pos_i, head.pos_j, head.pos_k, head.comp);
        c_waddr         = caddr(head.set, head.row, {1'b0, head.col});
        f_raddr         = faddr(pt_i, pt_j, pt_k, cmd_reg.comp);
        c_raddr         = caddr(cmd_reg.set, cmd_reg.row, m_reg);

        if (v3_reg)
            acc_next = acc_reg + 64'(rounded);

        case (state_reg)
            B_IDLE:
            begin
                f_raddr = f_waddr;
                if (!q_empty)
                begin
                    case (head.kind)
                        CMD_FIELD_WR:
                        begin
                            q_pop = 1'b1;
                            f_we  = 1'b1;
                        end
                        CMD_COEF_WR:
                        begin
                            q_pop = 1'b1;
                            c_we  = 1'b1;
                        end
                        CMD_BAD:
                        begin
                            if (out_free)
                            begin
                                q_pop           = 1'b1;
                                out_valid_next  = 1'b1;
                                derivative_next = '0;
                                status_next     = STATUS_BAD;
                            end
                        end
                        default:
                        begin
                            q_pop      = 1'b1;
                            cmd_next   = head;
                            state_next = B_CENTRE;
                        end
                    endcase
                end
            end
            B_CENTRE:
            begin
                centre_next = $signed(f_rdata);
                m_next      = '0;
                acc_next    = '0;
                state_next  = B_TAPS;
            end
            B_TAPS:
            begin
                if (m_reg < cmd_reg.taps)
                begin
                    v1_next = 1'b1;
                    m_next  = m_reg + 5'd1;
                end
                else if (!v1_reg && !v2_reg && !v3_reg)
                    state_next = B_FINISH;
            end
            B_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                    if (acc_reg > 64'sh7FFFFFFF)
                    begin
                        derivative_next = 32'h7FFFFFFF;
                        status_next     = STATUS_SAT;
                    end
                    else if (acc_reg < -64'sh80000000)
                    begin
                        derivative_next = 32'h80000000;
                        status_next     = STATUS_SAT;
                    end
                    else
                    begin
                        derivative_next = acc_reg[31:0];
                        status_next     = STATUS_OK;
                    end
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    assign out_valid  = out_valid_reg;
    assign derivative = derivative_reg;
    assign status     = status_reg;

endmodule
